>>> src/first_fit_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_page_allocator_defines
// assertion macros used by the allocator module
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// types and constants of the first-fit page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int PAGE_BYTES      = 16;
    localparam int PAGES_PER_BLOCK = 256;
    localparam int BLOCK_COUNT     = 16;
    localparam int BLOCK_BYTES     = PAGE_BYTES * PAGES_PER_BLOCK;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(PAGES_PER_BLOCK);
    localparam int BLK_W      = 4;
    localparam int ADDR_W     = BLK_W + PAGE_W;
    localparam int LEN_W      = PAGE_W;
    localparam int CNT_W      = PAGE_W + 1;
    localparam int SUM_W      = PAGE_W + 2;
    localparam int BIU_W      = $clog2(BLOCK_COUNT + 1);
    localparam int REQ_W      = 13;
    localparam int OFF_W      = 12;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_SPACE   = 3'd1,
        STAT_BAD_SIZE   = 3'd2,
        STAT_MISALIGNED = 3'd3,
        STAT_NOT_HEAD   = 3'd4
    } status_t;

    typedef struct packed {
        logic               func;
        logic [REQ_W-1:0]   req_bytes;
        logic [BLK_W-1:0]   rel_block;
        logic [OFF_W-1:0]   rel_offset;
    } cmd_beat_t;

    typedef struct packed {
        status_t            status;
        logic [BLK_W-1:0]   got_block;
        logic [OFF_W-1:0]   got_offset;
    } rsp_beat_t;

    typedef struct packed {
        logic               used;
        logic [LEN_W-1:0]   len;
    } entry_t;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [ADDR_W-1:0]  addr;
        entry_t             wdata;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_SPLIT,
        S_F_WRD,
        S_F_WEV,
        S_F_HRD,
        S_F_HEV,
        S_F_NRD,
        S_F_NEV,
        S_F_PCHK,
        S_F_WH
    } state_t;

endpackage

>>> src/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// first-fit page allocator with segment split on alloc and merge on free
// ----------------------------------------------------------------------------
// bad size, block or alignment is answered in the cycle after start; alloc reads
//   and checks each segment head in turn, free walks the heads before the freed
//   page and then merges with its neighbours; all through the one-port segment memory
// one command at a time: busy is high until done pulses, done lasts one cycle
// reset: every page free, one block in use; no clearing pass after reset
module first_fit_page_allocator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ffpa_pkg::cmd_beat_t   cmd,
    output logic                  done,
    output ffpa_pkg::rsp_beat_t   rsp
);

    `include "first_fit_page_allocator_defines.svh"

    ffpa_pkg::state_t    st_reg, st_next;
    ffpa_pkg::mem_req_t  mreq;
    ffpa_pkg::entry_t    rdata;
    ffpa_pkg::rsp_beat_t rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic [ffpa_pkg::BLK_W-1:0]  blk_reg, blk_next;
    logic [ffpa_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [ffpa_pkg::CNT_W-1:0]  p_reg, p_next;
    logic [ffpa_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [ffpa_pkg::PAGE_W-1:0] prev_reg, prev_next;
    logic                        have_prev_reg, have_prev_next;
    logic                        prev_used_reg, prev_used_next;
    logic [ffpa_pkg::CNT_W-1:0]  prev_len_reg, prev_len_next;
    logic [ffpa_pkg::CNT_W-1:0]  cur_len_reg, cur_len_next;
    logic [ffpa_pkg::SUM_W-1:0]  total_reg, total_next;
    logic [ffpa_pkg::PAGE_W-1:0] head_reg, head_next;
    logic [ffpa_pkg::BIU_W-1:0]  biu_reg, biu_next;

    logic [ffpa_pkg::REQ_W:0]    n_round;
    logic [ffpa_pkg::CNT_W-1:0]  rd_len;
    logic [ffpa_pkg::SUM_W-1:0]  p_sum;
    logic [ffpa_pkg::SUM_W-1:0]  split_end;
    logic [ffpa_pkg::BIU_W-1:0]  blk_inc;
    logic [ffpa_pkg::SUM_W-1:0]  total_cap;

    ffpa_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rdata)
    );

    assign n_round   = (ffpa_pkg::REQ_W+1)'(cmd.req_bytes)
                     + (ffpa_pkg::REQ_W+1)'(ffpa_pkg::PAGE_BYTES - 1);
    assign rd_len    = ffpa_pkg::CNT_W'(rdata.len) + 1'b1;
    assign p_sum     = ffpa_pkg::SUM_W'(p_reg) + ffpa_pkg::SUM_W'(rd_len);
    assign split_end = ffpa_pkg::SUM_W'(p_reg) + ffpa_pkg::SUM_W'(n_reg);
    assign blk_inc   = ffpa_pkg::BIU_W'(blk_reg) + 1'b1;
    assign total_cap = (total_reg > ffpa_pkg::SUM_W'(ffpa_pkg::PAGES_PER_BLOCK))
                     ? ffpa_pkg::SUM_W'(ffpa_pkg::PAGES_PER_BLOCK) : total_reg;

    always_comb
    begin
        st_next        = st_reg;
        rsp_next       = rsp_reg;
        done_next      = 1'b0;
        blk_next       = blk_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        page_next      = page_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        prev_used_next = prev_used_reg;
        prev_len_next  = prev_len_reg;
        cur_len_next   = cur_len_reg;
        total_next     = total_reg;
        head_next      = head_reg;
        biu_next       = biu_reg;
        mreq           = '0;

        unique case (st_reg)
            ffpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    rsp_next = '0;
                    if (cmd.func == ffpa_pkg::FUNC_ALLOC)
                    begin
                        if (cmd.req_bytes == '0 ||
                            cmd.req_bytes > ffpa_pkg::REQ_W'(ffpa_pkg::BLOCK_BYTES))
                        begin
                            rsp_next.status = ffpa_pkg::STAT_BAD_SIZE;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            n_next   = n_round[ffpa_pkg::PAGE_SHIFT +: ffpa_pkg::CNT_W];
                            blk_next = '0;
                            p_next   = '0;
                            st_next  = ffpa_pkg::S_A_RD;
                        end
                    end
                    else
                    begin
                        blk_next       = cmd.rel_block;
                        page_next      = cmd.rel_offset[ffpa_pkg::PAGE_SHIFT +:
                                                        ffpa_pkg::PAGE_W];
                        p_next         = '0;
                        have_prev_next = 1'b0;
                        if (ffpa_pkg::BIU_W'(cmd.rel_block) >= biu_reg)
                        begin
                            rsp_next.status = ffpa_pkg::STAT_NOT_HEAD;
                            done_next       = 1'b1;
                        end
                        else if (cmd.rel_offset[ffpa_pkg::PAGE_SHIFT-1:0] != '0)
                        begin
                            rsp_next.status = ffpa_pkg::STAT_MISALIGNED;
                            done_next       = 1'b1;
                        end
                        else if (cmd.rel_offset[ffpa_pkg::PAGE_SHIFT +:
                                                ffpa_pkg::PAGE_W] == '0)
                        begin
                            st_next = ffpa_pkg::S_F_HRD;
                        end
                        else
                        begin
                            st_next = ffpa_pkg::S_F_WRD;
                        end
                    end
                end
            end

            ffpa_pkg::S_A_RD:
            begin
                mreq.rd   = 1'b1;
                mreq.addr = {blk_reg, p_reg[ffpa_pkg::PAGE_W-1:0]};
                st_next   = ffpa_pkg::S_A_EV;
            end

            ffpa_pkg::S_A_EV:
            begin
                if (!rdata.used && rd_len >= n_reg)
                begin
                    mreq.wr         = 1'b1;
                    mreq.addr       = {blk_reg, p_reg[ffpa_pkg::PAGE_W-1:0]};
                    mreq.wdata.used = 1'b1;
                    mreq.wdata.len  = ffpa_pkg::LEN_W'(n_reg - 1'b1);
                    cur_len_next    = rd_len;
                    st_next         = ffpa_pkg::S_A_SPLIT;
                end
                else if (p_sum >= ffpa_pkg::SUM_W'(ffpa_pkg::PAGES_PER_BLOCK))
                begin
                    if (blk_inc >= ffpa_pkg::BIU_W'(ffpa_pkg::BLOCK_COUNT) ||
                        blk_inc > biu_reg)
                    begin
                        rsp_next.status = ffpa_pkg::STAT_NO_SPACE;
                        done_next       = 1'b1;
                        st_next         = ffpa_pkg::S_IDLE;
                    end
                    else
                    begin
                        blk_next = ffpa_pkg::BLK_W'(blk_inc);
                        p_next   = '0;
                        st_next  = ffpa_pkg::S_A_RD;
                    end
                end
                else
                begin
                    p_next  = ffpa_pkg::CNT_W'(p_sum);
                    st_next = ffpa_pkg::S_A_RD;
                end
            end

            ffpa_pkg::S_A_SPLIT:
            begin
                // remainder of the free segment becomes a new free head
                if (cur_len_reg > n_reg &&
                    split_end < ffpa_pkg::SUM_W'(ffpa_pkg::PAGES_PER_BLOCK))
                begin
                    mreq.wr         = 1'b1;
                    mreq.addr       = {blk_reg, split_end[ffpa_pkg::PAGE_W-1:0]};
                    mreq.wdata.used = 1'b0;
                    mreq.wdata.len  = ffpa_pkg::LEN_W'(cur_len_reg - n_reg - 1'b1);
                end
                if (ffpa_pkg::BIU_W'(blk_reg) >= biu_reg)
                begin
                    biu_next = blk_inc;
                end
                rsp_next.status     = ffpa_pkg::STAT_OK;
                rsp_next.got_block  = blk_reg;
                rsp_next.got_offset = {p_reg[ffpa_pkg::PAGE_W-1:0],
                                       ffpa_pkg::PAGE_SHIFT'(0)};
                done_next           = 1'b1;
                st_next             = ffpa_pkg::S_IDLE;
            end

            ffpa_pkg::S_F_WRD:
            begin
                mreq.rd   = 1'b1;
                mreq.addr = {blk_reg, p_reg[ffpa_pkg::PAGE_W-1:0]};
                st_next   = ffpa_pkg::S_F_WEV;
            end

            ffpa_pkg::S_F_WEV:
            begin
                prev_next      = p_reg[ffpa_pkg::PAGE_W-1:0];
                have_prev_next = 1'b1;
                prev_used_next = rdata.used;
                prev_len_next  = rd_len;
                if (p_sum < ffpa_pkg::SUM_W'(page_reg))
                begin
                    p_next  = ffpa_pkg::CNT_W'(p_sum);
                    st_next = ffpa_pkg::S_F_WRD;
                end
                else if (p_sum != ffpa_pkg::SUM_W'(page_reg))
                begin
                    rsp_next.status = ffpa_pkg::STAT_NOT_HEAD;
                    done_next       = 1'b1;
                    st_next         = ffpa_pkg::S_IDLE;
                end
                else
                begin
                    st_next = ffpa_pkg::S_F_HRD;
                end
            end

            ffpa_pkg::S_F_HRD:
            begin
                mreq.rd   = 1'b1;
                mreq.addr = {blk_reg, page_reg};
                st_next   = ffpa_pkg::S_F_HEV;
            end

            ffpa_pkg::S_F_HEV:
            begin
                if (!rdata.used)
                begin
                    rsp_next.status = ffpa_pkg::STAT_NOT_HEAD;
                    done_next       = 1'b1;
                    st_next         = ffpa_pkg::S_IDLE;
                end
                else
                begin
                    cur_len_next = rd_len;
                    total_next   = ffpa_pkg::SUM_W'(rd_len);
                    head_next    = page_reg;
                    p_next       = ffpa_pkg::CNT_W'(ffpa_pkg::SUM_W'(page_reg)
                                                    + ffpa_pkg::SUM_W'(rd_len));
                    if (ffpa_pkg::SUM_W'(page_reg) + ffpa_pkg::SUM_W'(rd_len)
                        < ffpa_pkg::SUM_W'(ffpa_pkg::PAGES_PER_BLOCK))
                    begin
                        st_next = ffpa_pkg::S_F_NRD;
                    end
                    else
                    begin
                        st_next = ffpa_pkg::S_F_PCHK;
                    end
                end
            end

            ffpa_pkg::S_F_NRD:
            begin
                mreq.rd   = 1'b1;
                mreq.addr = {blk_reg, p_reg[ffpa_pkg::PAGE_W-1:0]};
                st_next   = ffpa_pkg::S_F_NEV;
            end

            ffpa_pkg::S_F_NEV:
            begin
                // merge with a free next segment
                if (!rdata.used)
                begin
                    total_next = total_reg + ffpa_pkg::SUM_W'(rd_len);
                    mreq.wr    = 1'b1;
                    mreq.addr  = {blk_reg, p_reg[ffpa_pkg::PAGE_W-1:0]};
                end
                st_next = ffpa_pkg::S_F_PCHK;
            end

            ffpa_pkg::S_F_PCHK:
            begin
                // merge with a free previous segment
                if (have_prev_reg && !prev_used_reg)
                begin
                    total_next = total_reg + ffpa_pkg::SUM_W'(prev_len_reg);
                    head_next  = prev_reg;
                    mreq.wr    = 1'b1;
                    mreq.addr  = {blk_reg, page_reg};
                end
                st_next = ffpa_pkg::S_F_WH;
            end

            ffpa_pkg::S_F_WH:
            begin
                mreq.wr         = 1'b1;
                mreq.addr       = {blk_reg, head_reg};
                mreq.wdata.used = 1'b0;
                mreq.wdata.len  = ffpa_pkg::LEN_W'(total_cap - 1'b1);
                rsp_next.status = ffpa_pkg::STAT_OK;
                done_next       = 1'b1;
                st_next         = ffpa_pkg::S_IDLE;
            end

            default:
            begin
                st_next = ffpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ffpa_pkg::S_IDLE;
            done_reg <= 1'b0;
            biu_reg  <= ffpa_pkg::BIU_W'(1);
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            biu_reg  <= biu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        blk_reg       <= blk_next;
        n_reg         <= n_next;
        p_reg         <= p_next;
        page_reg      <= page_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        prev_used_reg <= prev_used_next;
        prev_len_reg  <= prev_len_next;
        cur_len_reg   <= cur_len_next;
        total_reg     <= total_next;
        head_reg      <= head_next;
    end

    assign busy = (st_reg != ffpa_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `FFPA_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
    `FFPA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done,
        "accepted command neither started nor answered")
    `FFPA_ASSERT_NOW(a_biu_range, 1'b1,
        biu_reg != '0 && biu_reg <= ffpa_pkg::BIU_W'(ffpa_pkg::BLOCK_COUNT),
        "blocks in use out of range")
    `FFPA_ASSERT_NOW(a_fail_zero, done && rsp.status != ffpa_pkg::STAT_OK,
        rsp.got_block == '0 && rsp.got_offset == '0, "failed beat carries a region")

endmodule

>>> src/ffpa_store.sv
// ----------------------------------------------------------------------------
// ffpa_store
// per-page segment memory (used flag and length) with block head defaults
// ----------------------------------------------------------------------------
module ffpa_store (
    input  logic              clk,
    input  logic              rst_n,
    input  ffpa_pkg::mem_req_t req,
    output ffpa_pkg::entry_t  rdata
);

    ffpa_pkg::entry_t mem [ffpa_pkg::BLOCK_COUNT * ffpa_pkg::PAGES_PER_BLOCK];
    ffpa_pkg::entry_t rd_q_reg;

    logic [ffpa_pkg::BLOCK_COUNT-1:0] head_ok_reg;
    logic [ffpa_pkg::BLOCK_COUNT-1:0] head_ok_next;
    logic                             dflt_reg;
    logic                             dflt_next;
    logic                             page_zero;
    logic [ffpa_pkg::BLK_W-1:0]       blk;

    assign blk       = req.addr[ffpa_pkg::ADDR_W-1 -: ffpa_pkg::BLK_W];
    assign page_zero = (req.addr[ffpa_pkg::PAGE_W-1:0] == '0);

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_q_reg <= mem[req.addr];
        end
    end

    always_comb
    begin
        head_ok_next = head_ok_reg;
        dflt_next    = dflt_reg;
        if (req.wr && page_zero)
        begin
            head_ok_next[blk] = 1'b1;
        end
        if (req.rd)
        begin
            dflt_next = page_zero && !head_ok_reg[blk];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ok_reg <= '0;
            dflt_reg    <= 1'b0;
        end
        else
        begin
            head_ok_reg <= head_ok_next;
            dflt_reg    <= dflt_next;
        end
    end

    // untouched block head reads as one free segment over the whole block
    always_comb
    begin
        if (dflt_reg)
        begin
            rdata.used = 1'b0;
            rdata.len  = ffpa_pkg::LEN_W'(ffpa_pkg::PAGES_PER_BLOCK - 1);
        end
        else
        begin
            rdata = rd_q_reg;
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit page allocator: a behavioral model of
// the page arena predicts status, block and offset of every command beat, and
// a scoreboard compares each done beat against the oldest prediction
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS_PER_PHASE = 288;

    class arena_scoreboard;
        bit          page_used [ffpa_pkg::BLOCK_COUNT][ffpa_pkg::PAGES_PER_BLOCK];
        int unsigned seg_last  [ffpa_pkg::BLOCK_COUNT][ffpa_pkg::PAGES_PER_BLOCK];
        int unsigned live_blocks;
        ffpa_pkg::rsp_beat_t pending [$];
        ffpa_pkg::rsp_beat_t granted [$];
        int          errors;

        function void clear_arena();
            for (int b = 0; b < ffpa_pkg::BLOCK_COUNT; b++)
            begin
                for (int p = 0; p < ffpa_pkg::PAGES_PER_BLOCK; p++)
                begin
                    page_used[b][p] = 0;
                    seg_last[b][p]  = 0;
                end
                seg_last[b][0] = ffpa_pkg::PAGES_PER_BLOCK - 1;
            end
            live_blocks = 1;
            errors      = 0;
        endfunction

        function ffpa_pkg::rsp_beat_t place(int unsigned nbytes);
            ffpa_pkg::rsp_beat_t r;
            int unsigned         n;
            int unsigned         p;
            int unsigned         len;
            r = '0;
            r.status = ffpa_pkg::STAT_NO_SPACE;
            if (nbytes == 0 || nbytes > ffpa_pkg::BLOCK_BYTES)
            begin
                r.status = ffpa_pkg::STAT_BAD_SIZE;
                return r;
            end
            n = (nbytes + ffpa_pkg::PAGE_BYTES - 1) / ffpa_pkg::PAGE_BYTES;
            for (int unsigned b = 0; b < ffpa_pkg::BLOCK_COUNT && b <= live_blocks; b++)
            begin
                p = 0;
                while (p < ffpa_pkg::PAGES_PER_BLOCK)
                begin
                    len = seg_last[b][p] + 1;
                    if (!page_used[b][p] && len >= n)
                    begin
                        for (int unsigned k = 0; k < n; k++)
                            page_used[b][p+k] = 1;
                        if (len > n && p + n < ffpa_pkg::PAGES_PER_BLOCK)
                            seg_last[b][p+n] = len - n - 1;
                        seg_last[b][p] = n - 1;
                        if (b >= live_blocks)
                            live_blocks = b + 1;
                        r.status     = ffpa_pkg::STAT_OK;
                        r.got_block  = b[ffpa_pkg::BLK_W-1:0];
                        r.got_offset = ffpa_pkg::OFF_W'(p * ffpa_pkg::PAGE_BYTES);
                        return r;
                    end
                    p += len;
                end
            end
            return r;
        endfunction

        function ffpa_pkg::rsp_beat_t release_seg(int unsigned b, int unsigned off);
            ffpa_pkg::rsp_beat_t r;
            int unsigned         page, p, prv, len, head, total, nxt;
            bit                  has_prev;
            r = '0;
            if (b >= live_blocks || b >= ffpa_pkg::BLOCK_COUNT)
            begin
                r.status = ffpa_pkg::STAT_NOT_HEAD;
                return r;
            end
            if (off % ffpa_pkg::PAGE_BYTES != 0)
            begin
                r.status = ffpa_pkg::STAT_MISALIGNED;
                return r;
            end
            page = off / ffpa_pkg::PAGE_BYTES;
            if (page >= ffpa_pkg::PAGES_PER_BLOCK)
            begin
                r.status = ffpa_pkg::STAT_NOT_HEAD;
                return r;
            end
            p = 0;
            prv = 0;
            has_prev = 0;
            while (p < page)
            begin
                prv = p;
                has_prev = 1;
                p += seg_last[b][p] + 1;
            end
            if (p != page || !page_used[b][page])
            begin
                r.status = ffpa_pkg::STAT_NOT_HEAD;
                return r;
            end
            len   = seg_last[b][page] + 1;
            head  = page;
            total = len;
            nxt   = page + len;
            if (nxt < ffpa_pkg::PAGES_PER_BLOCK && !page_used[b][nxt])
            begin
                total += seg_last[b][nxt] + 1;
                seg_last[b][nxt] = 0;
            end
            if (has_prev && !page_used[b][prv])
            begin
                total += seg_last[b][prv] + 1;
                seg_last[b][page] = 0;
                head = prv;
            end
            if (total > ffpa_pkg::PAGES_PER_BLOCK)
                total = ffpa_pkg::PAGES_PER_BLOCK;
            seg_last[b][head] = total - 1;
            for (int unsigned k = 0; k < len; k++)
                page_used[b][page+k] = 0;
            r.status = ffpa_pkg::STAT_OK;
            return r;
        endfunction

        function void note_cmd(ffpa_pkg::cmd_beat_t c);
            ffpa_pkg::rsp_beat_t r;
            if (c.func == ffpa_pkg::FUNC_ALLOC)
            begin
                r = place(32'(c.req_bytes));
                if (r.status == ffpa_pkg::STAT_OK)
                    granted.push_back(r);
            end
            else
            begin
                r = release_seg(32'(c.rel_block), 32'(c.rel_offset));
            end
            pending.push_back(r);
        endfunction

        function void check_rsp(ffpa_pkg::rsp_beat_t got);
            ffpa_pkg::rsp_beat_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.got_block !== want.got_block)
            begin
                $display("%0t: block expected %0d actual %0d", $time, want.got_block,
                    got.got_block);
                errors++;
            end
            if (got.got_offset !== want.got_offset)
            begin
                $display("%0t: offset expected %0d actual %0d", $time, want.got_offset,
                    got.got_offset);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    ffpa_pkg::cmd_beat_t cmd;
    logic                done;
    ffpa_pkg::rsp_beat_t rsp;

    arena_scoreboard arena;
    int              idle_pct;
    int              phase_idle [4] = '{0, 62, 0, 29};

    first_fit_page_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            arena.check_rsp(rsp);
        end
        if (rst_n && start && !busy)
        begin
            arena.note_cmd(cmd);
        end
    end

    function automatic ffpa_pkg::cmd_beat_t make_cmd();
        ffpa_pkg::cmd_beat_t c;
        ffpa_pkg::rsp_beat_t g;
        int unsigned         pick;
        int unsigned         idx;
        c    = '0;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            c.func = ffpa_pkg::FUNC_ALLOC;
            pick   = $urandom_range(99);
            if (pick < 4)
                c.req_bytes = '0;
            else if (pick < 8)
                c.req_bytes = ffpa_pkg::REQ_W'($urandom_range(8191, 4097));
            else if (pick < 10)
                c.req_bytes = ffpa_pkg::REQ_W'(ffpa_pkg::BLOCK_BYTES);
            else if (pick < 55)
                c.req_bytes = ffpa_pkg::REQ_W'($urandom_range(64, 1));
            else if (pick < 85)
                c.req_bytes = ffpa_pkg::REQ_W'($urandom_range(1024, 65));
            else
                c.req_bytes = ffpa_pkg::REQ_W'($urandom_range(4096, 1025));
        end
        else
        begin
            c.func = ffpa_pkg::FUNC_FREE;
            if (arena.granted.size() != 0 && $urandom_range(99) < 75)
            begin
                idx = $urandom_range(arena.granted.size() - 1);
                g   = arena.granted[idx];
                arena.granted.delete(idx);
                c.rel_block  = g.got_block;
                c.rel_offset = g.got_offset;
            end
            else
            begin
                c.rel_block  = ffpa_pkg::BLK_W'($urandom);
                c.rel_offset = ffpa_pkg::OFF_W'($urandom);
                if ($urandom_range(1) == 0)
                    c.rel_offset[ffpa_pkg::PAGE_SHIFT-1:0] = '0;
            end
        end
        return c;
    endfunction

    task automatic send(ffpa_pkg::cmd_beat_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        arena = new();
        arena.clear_arena();
        idle_pct = 0;
        start <= 1'b0;
        cmd   <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send(make_cmd());
        end
        start <= 1'b0;
        while (arena.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
        if (arena.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #500000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
